/* rtl/text_terminal_cell_buffer_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the text terminal cell buffer
// Concurrent assertions clocked on the rising edge, off while reset is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_CELL_BUFFER_TOP_ASSERT_SVH
`define TEXT_TERMINAL_CELL_BUFFER_TOP_ASSERT_SVH

// Explicit clock and reset
`define TTCB_ASSERT_CLK(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("ttcb: assertion failed");

// Uses clk and rst_n from the enclosing scope
`define TTCB_ASSERT(lbl, prop) `TTCB_ASSERT_CLK(lbl, clk, rst_n, prop)

`endif

/* rtl/ttcb_pkg.sv */
// ----------------------------------------------------------------------------
// ttcb_pkg
// Shared constants, item types, commands and helpers of the cell buffer.
// ----------------------------------------------------------------------------
package ttcb_pkg;

  // Grid geometry
  localparam int COLS   = 48;
  localparam int ROWS   = 14;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);

  // Field widths
  localparam int KIND_W = 2;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 4;
  localparam int COL_W  = 6;

  // Character codes
  localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_SPACE   = 8'd32;

  // Request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_PUT   = 2'd0,
    KIND_ERASE = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
  } out_item_t;

  // Cursor operations
  typedef enum logic [2:0] {
    CUR_HOLD    = 3'd0,
    CUR_NEWROW  = 3'd1,
    CUR_ADVANCE = 3'd2,
    CUR_BACK    = 3'd3,
    CUR_HOME    = 3'd4
  } cur_op_t;

  // Controller to datapath
  typedef struct packed {
    cur_op_t cur_op;
    logic    in_rdy;     // take an item
    logic    scroll;     // rotate top row, start bottom row clear
    logic    clear_all;  // start whole grid clear
    logic    sweep_wr;   // write zero at sweep address
    logic    cell_wr;    // write a character at the cursor
    logic    wr_space;   // write a space instead of the item code
    logic    rd_cell;    // read the requested cell
    logic    out_load;   // load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic  in_acc;
    kind_t kind;
    logic  newline;
    logic  col_full;
    logic  row_last;
    logic  sweep_done;
    logic  out_free;
  } stat_t;

  // Logical row to physical row under the scroll rotation
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                input logic [ROW_W-1:0] top);
    logic [ROW_W:0] sum;
    sum = {1'b0, r} + {1'b0, top};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  // Physical row and column to memory address
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(prow) * ADDR_W'(COLS) + ADDR_W'(col);
  endfunction

endpackage

/* rtl/ttcb_ifs.sv */
// ----------------------------------------------------------------------------
// ttcb channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------

// Request channel
interface ttcb_in_if;
  logic               valid;
  logic               ready;
  ttcb_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Result channel
interface ttcb_out_if;
  logic                valid;
  logic                ready;
  ttcb_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/ttcb_ctrl.sv */
// ----------------------------------------------------------------------------
// ttcb_ctrl
// Sequencer: decodes the latched item and steps the datapath through
// writes, row and grid clears, reads and the result load.
// ----------------------------------------------------------------------------
module ttcb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  ttcb_pkg::stat_t  stat,
  output ttcb_pkg::cmd_t   cmd
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLR_ROW,
    ST_CLR_ALL,
    ST_WRITE,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   pend_wr_r, pend_wr_nxt;  // character still to store after a row clear
  logic   done;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    pend_wr_nxt = pend_wr_r;
    done        = 1'b0;
    cmd         = '0;
    cmd.cur_op  = ttcb_pkg::CUR_HOLD;

    unique case (state_r)
      ST_INIT: begin
        cmd.sweep_wr = 1'b1;
        if (stat.sweep_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.in_rdy = 1'b1;
        if (stat.in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (stat.kind)
          ttcb_pkg::KIND_PUT: begin
            if (stat.newline || stat.col_full) begin
              // move to next row, scrolling off the bottom
              cmd.cur_op  = ttcb_pkg::CUR_NEWROW;
              pend_wr_nxt = !stat.newline;
              if (stat.row_last) begin
                cmd.scroll = 1'b1;
                state_nxt  = ST_CLR_ROW;
              end else if (!stat.newline) begin
                state_nxt = ST_WRITE;
              end else begin
                done = 1'b1;
              end
            end else begin
              cmd.cell_wr = 1'b1;
              cmd.cur_op  = ttcb_pkg::CUR_ADVANCE;
              done        = 1'b1;
            end
          end
          ttcb_pkg::KIND_ERASE: begin
            cmd.cell_wr  = 1'b1;
            cmd.wr_space = 1'b1;
            cmd.cur_op   = ttcb_pkg::CUR_BACK;
            done         = 1'b1;
          end
          ttcb_pkg::KIND_CLEAR: begin
            cmd.cur_op    = ttcb_pkg::CUR_HOME;
            cmd.clear_all = 1'b1;
            state_nxt     = ST_CLR_ALL;
          end
          ttcb_pkg::KIND_READ: begin
            cmd.rd_cell = 1'b1;
            state_nxt   = ST_FINISH;
          end
          default: begin
            state_nxt = ST_FINISH;
          end
        endcase
      end
      ST_CLR_ROW: begin
        cmd.sweep_wr = 1'b1;
        if (stat.sweep_done) begin
          if (pend_wr_r) begin
            state_nxt = ST_WRITE;
          end else begin
            done = 1'b1;
          end
        end
      end
      ST_CLR_ALL: begin
        cmd.sweep_wr = 1'b1;
        if (stat.sweep_done) begin
          done = 1'b1;
        end
      end
      ST_WRITE: begin
        cmd.cell_wr = 1'b1;
        cmd.cur_op  = ttcb_pkg::CUR_ADVANCE;
        done        = 1'b1;
      end
      ST_FINISH: begin
        done = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Hand the result over once the output register is free
    if (done) begin
      if (stat.out_free) begin
        cmd.out_load = 1'b1;
        state_nxt    = ST_IDLE;
      end else begin
        state_nxt = ST_FINISH;
      end
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_INIT;
      pend_wr_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pend_wr_r <= pend_wr_nxt;
    end
  end

endmodule

/* rtl/ttcb_datapath.sv */
// ----------------------------------------------------------------------------
// ttcb_datapath
// Cell memory, cursor and scroll rotation, clear sweep counter, item
// register and result register.
// ----------------------------------------------------------------------------
module ttcb_datapath (
  input  logic             clk,
  input  logic             rst_n,
  ttcb_in_if.sink          in_chan,
  ttcb_out_if.source       out_chan,
  input  ttcb_pkg::cmd_t   cmd,
  output ttcb_pkg::stat_t  stat
);

  // Cell memory, rows rotated by top_r
  logic [ttcb_pkg::CHAR_W-1:0] cell_mem_r [ttcb_pkg::CELLS];

  ttcb_pkg::in_item_t          item_r;
  logic [ttcb_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [ttcb_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [ttcb_pkg::ROW_W-1:0]  top_r, top_nxt;
  logic [ttcb_pkg::ADDR_W-1:0] sweep_addr_r, sweep_addr_nxt;
  logic [ttcb_pkg::ADDR_W-1:0] sweep_last_r, sweep_last_nxt;
  logic [ttcb_pkg::CHAR_W-1:0] rdata_r;
  logic                        out_valid_r;
  ttcb_pkg::out_item_t         out_data_r;

  logic                        in_acc;
  logic                        row_last;
  logic [ttcb_pkg::COL_W-1:0]  col_back;
  logic [ttcb_pkg::COL_W-1:0]  wr_col;
  logic [ttcb_pkg::ADDR_W-1:0] row_base;
  logic                        wr_en;
  logic [ttcb_pkg::ADDR_W-1:0] wr_addr;
  logic [ttcb_pkg::CHAR_W-1:0] wr_data;
  logic                        rd_ok;
  logic [ttcb_pkg::ADDR_W-1:0] rd_addr;
  ttcb_pkg::out_item_t         out_nxt;

  // Handshake and status
  assign in_chan.ready  = cmd.in_rdy;
  assign in_acc         = in_chan.valid && cmd.in_rdy;
  assign row_last       = (row_r == ttcb_pkg::ROW_W'(ttcb_pkg::ROWS - 1));

  assign stat.in_acc     = in_acc;
  assign stat.kind       = item_r.kind;
  assign stat.newline    = (item_r.char_code == ttcb_pkg::CODE_NEWLINE);
  assign stat.col_full   = (col_r == ttcb_pkg::COL_W'(ttcb_pkg::COLS));
  assign stat.row_last   = row_last;
  assign stat.sweep_done = (sweep_addr_r == sweep_last_r);
  assign stat.out_free   = !out_valid_r || out_chan.ready;

  assign col_back = (col_r != '0) ? col_r - 1'b1 : '0;

  // Cursor and rotation update
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    top_nxt = top_r;
    case (cmd.cur_op)
      ttcb_pkg::CUR_NEWROW: begin
        col_nxt = '0;
        if (!row_last) begin
          row_nxt = row_r + 1'b1;
        end
      end
      ttcb_pkg::CUR_ADVANCE: col_nxt = col_r + 1'b1;
      ttcb_pkg::CUR_BACK:    col_nxt = col_back;
      ttcb_pkg::CUR_HOME: begin
        row_nxt = '0;
        col_nxt = '0;
        top_nxt = '0;
      end
      default: ;
    endcase
    if (cmd.scroll) begin
      top_nxt = (top_r == ttcb_pkg::ROW_W'(ttcb_pkg::ROWS - 1)) ? '0 : top_r + 1'b1;
    end
  end

  // Clear sweep: whole grid, or the row that scrolls to the bottom
  assign row_base = ttcb_pkg::cell_addr(top_r, '0);

  always_comb begin
    sweep_addr_nxt = sweep_addr_r;
    sweep_last_nxt = sweep_last_r;
    if (cmd.clear_all) begin
      sweep_addr_nxt = '0;
      sweep_last_nxt = ttcb_pkg::ADDR_W'(ttcb_pkg::CELLS - 1);
    end else if (cmd.scroll) begin
      sweep_addr_nxt = row_base;
      sweep_last_nxt = row_base + ttcb_pkg::ADDR_W'(ttcb_pkg::COLS - 1);
    end else if (cmd.sweep_wr && !stat.sweep_done) begin
      sweep_addr_nxt = sweep_addr_r + 1'b1;
    end
  end

  // Write port
  assign wr_col  = (cmd.cur_op == ttcb_pkg::CUR_BACK) ? col_back : col_r;
  assign wr_en   = cmd.sweep_wr || cmd.cell_wr;
  assign wr_addr = cmd.sweep_wr ? sweep_addr_r
                 : ttcb_pkg::cell_addr(ttcb_pkg::phys_row(row_r, top_r), wr_col);
  assign wr_data = cmd.sweep_wr ? '0
                 : (cmd.wr_space ? ttcb_pkg::CODE_SPACE : item_r.char_code);

  // Read port, out-of-grid reads answer zero
  assign rd_ok   = (item_r.read_row < ttcb_pkg::ROW_W'(ttcb_pkg::ROWS)) &&
                   (item_r.read_col < ttcb_pkg::COL_W'(ttcb_pkg::COLS));
  assign rd_addr = rd_ok ? ttcb_pkg::cell_addr(ttcb_pkg::phys_row(item_r.read_row, top_r),
                                               item_r.read_col)
                         : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cell_mem_r[wr_addr] <= wr_data;
    end
    if (cmd.rd_cell) begin
      rdata_r <= cell_mem_r[rd_addr];
    end
  end

  // Result payload
  always_comb begin
    out_nxt.cell_char  = ((item_r.kind == ttcb_pkg::KIND_READ) && rd_ok) ? rdata_r : '0;
    out_nxt.cursor_row = row_nxt;
    out_nxt.cursor_col = col_nxt;
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_chan.data;
    end
    if (cmd.out_load) begin
      out_data_r <= out_nxt;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r        <= '0;
      col_r        <= '0;
      top_r        <= '0;
      sweep_addr_r <= '0;
      sweep_last_r <= ttcb_pkg::ADDR_W'(ttcb_pkg::CELLS - 1);
      out_valid_r  <= 1'b0;
    end else begin
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      top_r        <= top_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_last_r <= sweep_last_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

endmodule

/* rtl/text_terminal_cell_buffer_top.sv */
// ----------------------------------------------------------------------------
// text_terminal_cell_buffer_top
// Character-cell terminal buffer, 14 rows by 48 columns, with cursor,
// newline, wrap, scroll, erase, clear and cell read.
//
//   Channel   Dir  Handshake          Payload
//   in_chan   in   valid/ready        kind, char_code, read_row, read_col
//   out_chan  out  valid/ready        cell_char, cursor_row, cursor_col
//
// One item at a time: put char, newline and erase finish in the exec state; read adds a finish state.
// A scroll clears the new bottom row one cell a cycle, then a wrapping put writes its char.
// Clear screen sweeps every cell and homes the cursor.
// After reset the grid is cleared before in_chan.ready rises.
// A result stalled in the output register holds the next result, and ready with it.
// ----------------------------------------------------------------------------
module text_terminal_cell_buffer_top (
  input  logic         clk,
  input  logic         rst_n,
  ttcb_in_if.sink      in_chan,
  ttcb_out_if.source   out_chan
);

  ttcb_pkg::cmd_t  cmd;
  ttcb_pkg::stat_t stat;

  // Sequencer
  ttcb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Memory, cursor and result register
  ttcb_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

/* rtl/ttcb_checker.sv */
// ----------------------------------------------------------------------------
// ttcb_checker
// Port-level checks on the cell buffer, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_terminal_cell_buffer_top_assert.svh"

module ttcb_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ttcb_pkg::CHAR_W-1:0] out_char,
  input logic [ttcb_pkg::ROW_W-1:0]  out_row,
  input logic [ttcb_pkg::COL_W-1:0]  out_col
);

  // Whole result payload
  logic [ttcb_pkg::CHAR_W+ttcb_pkg::ROW_W+ttcb_pkg::COL_W-1:0] out_word;
  assign out_word = {out_char, out_row, out_col};

  // A stalled result stays offered
  `TTCB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)

  // A stalled result keeps its payload
  `TTCB_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_word))

  // One item in work at a time: ready drops right after an accept
  `TTCB_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready)

  // Cursor row stays inside the grid
  `TTCB_ASSERT(a_row_range, out_valid |-> out_row < ttcb_pkg::ROW_W'(ttcb_pkg::ROWS))

  // Cursor column never passes the wrap-pending position
  `TTCB_ASSERT(a_col_range, out_valid |-> out_col <= ttcb_pkg::COL_W'(ttcb_pkg::COLS))

endmodule

bind text_terminal_cell_buffer_top ttcb_checker u_ttcb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_char  (out_chan.data.cell_char),
  .out_row   (out_chan.data.cursor_row),
  .out_col   (out_chan.data.cursor_col)
);
